@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the staging buffer controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define SBC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define SBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/sbc_pkg.sv @@
// Types, constants and codes shared by the staging buffer controller.
`default_nettype none

package sbc_pkg;

  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned LEN_W        = 32;
  localparam int unsigned OFF_W        = 20;
  localparam int unsigned MAX_CAPACITY = 1048576;
  localparam int unsigned WLEN_W       = $clog2(MAX_CAPACITY) + 1;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = ADDR_W;

  localparam logic [WLEN_W-1:0] CAP_MAX   = WLEN_W'(MAX_CAPACITY);
  localparam logic [WLEN_W-1:0] CAP_RESET = WLEN_W'(65536);

  localparam logic [CFG_IDX_W-1:0] CFG_SIEVING  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END      = 2'd2;

  typedef enum logic [2:0] {
    CMD_COPY_OUT  = 3'd0,
    CMD_COPY_IN   = 3'd1,
    CMD_FLUSH     = 3'd2,
    CMD_REFILL    = 3'd3,
    CMD_DIRECT_RD = 3'd4,
    CMD_DIRECT_WR = 3'd5
  } cmd_code_e;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] req_addr;
    logic [LEN_W-1:0]  req_len;
  } req_t;

  typedef struct packed {
    cmd_code_e         cmd_code;
    logic [ADDR_W-1:0] cmd_addr;
    logic [LEN_W-1:0]  cmd_len;
    logic [OFF_W-1:0]  buf_offset;
    logic              last;
  } cmd_t;

  typedef struct packed {
    logic              sieving_enabled;
    logic [WLEN_W-1:0] buf_capacity;
    logic [ADDR_W-1:0] end_of_space;
  } cfg_t;

  typedef struct packed {
    logic              flush_en;
    logic              refill_en;
    cmd_code_e         main_code;
    logic [ADDR_W-1:0] flush_start;
    logic [WLEN_W-1:0] flush_len;
    logic [WLEN_W-1:0] fill_len;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  offset;
  } plan_t;

endpackage

`default_nettype wire

@@ hw/rtl/sieve_buffer_controller.sv @@
// Top level of the staging buffer controller: configuration registers and the three parts.
//
// Channel   Direction  Handshake                 Payload
// req       in         req_valid_i / req_ready_o  sbc_pkg::req_t
// cmd       out        cmd_valid_o / cmd_ready_i  sbc_pkg::cmd_t
// cfg       in         cfg_we_i (no wait)         cfg_idx_i, cfg_wdata_i
//
// Each request yields one to three commands, one per cycle while cmd_ready_i is high, so
// the command port is the limiting resource.
// A request passes the front-end register, the plan queue, the plan register and the command register in turn.
// Reset empties the window, enables sieving and sets the capacity to 64 KiB.
// A stalled command port fills the plan queue and then holds off requests.
`default_nettype none

module sieve_buffer_controller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [sbc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [sbc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic                              req_valid_i,
  output logic                                   req_ready_o,
  input  wire sbc_pkg::req_t                     req_i,
  output logic                                   cmd_valid_o,
  input  wire logic                              cmd_ready_i,
  output sbc_pkg::cmd_t                          cmd_o
);

  sbc_pkg::cfg_t  cfg_q;
  logic           fq_valid, fq_ready;
  sbc_pkg::plan_t fq_plan;
  logic           qb_valid, qb_ready;
  sbc_pkg::plan_t qb_plan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sieving_enabled <= 1'b1;
      cfg_q.buf_capacity    <= sbc_pkg::CAP_RESET;
      cfg_q.end_of_space    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sbc_pkg::CFG_SIEVING:  cfg_q.sieving_enabled <= cfg_wdata_i[0];
        sbc_pkg::CFG_CAPACITY: cfg_q.buf_capacity    <= cfg_wdata_i[sbc_pkg::WLEN_W-1:0];
        sbc_pkg::CFG_END:      cfg_q.end_of_space    <= cfg_wdata_i[sbc_pkg::ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sbc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .req_valid_i  (req_valid_i),
    .req_ready_o  (req_ready_o),
    .req_i        (req_i),
    .plan_valid_o (fq_valid),
    .plan_ready_i (fq_ready),
    .plan_o       (fq_plan)
  );

  sbc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_plan),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_plan)
  );

  sbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .plan_valid_i (qb_valid),
    .plan_ready_o (qb_ready),
    .plan_i       (qb_plan),
    .cmd_valid_o  (cmd_valid_o),
    .cmd_ready_i  (cmd_ready_i),
    .cmd_o        (cmd_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/sbc_front.sv @@
// Front end: takes requests, keeps the window state and turns each request into a plan.
`default_nettype none

module sbc_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire sbc_pkg::cfg_t cfg_i,
  input  wire logic         req_valid_i,
  output logic              req_ready_o,
  input  wire sbc_pkg::req_t req_i,
  output logic              plan_valid_o,
  input  wire logic         plan_ready_i,
  output sbc_pkg::plan_t    plan_o
);

  logic [sbc_pkg::WLEN_W-1:0] cap_eff;
  logic [sbc_pkg::ADDR_W-1:0] room;
  logic [sbc_pkg::WLEN_W-1:0] fill_in;
  logic                       over_in;

  logic                       a_valid_q, a_valid_d;
  sbc_pkg::req_t              a_req_q;
  logic [sbc_pkg::WLEN_W-1:0] a_fill_q;
  logic                       a_over_q;

  logic [sbc_pkg::ADDR_W-1:0] ws_q, ws_d;
  logic [sbc_pkg::WLEN_W-1:0] wlen_q, wlen_d;
  logic                       dirty_q, dirty_d;

  logic [sbc_pkg::ADDR_W-1:0] fwd;
  logic [sbc_pkg::ADDR_W-1:0] rev;
  logic [sbc_pkg::WLEN_W-1:0] rest;
  logic                       in_win;
  logic                       hit;
  logic                       ovl;
  logic                       push;
  logic                       take;
  sbc_pkg::plan_t             plan;

  always_comb begin
    if (cfg_i.buf_capacity == '0) begin
      cap_eff = sbc_pkg::WLEN_W'(1);
    end else if (cfg_i.buf_capacity > sbc_pkg::CAP_MAX) begin
      cap_eff = sbc_pkg::CAP_MAX;
    end else begin
      cap_eff = cfg_i.buf_capacity;
    end
    room    = (cfg_i.end_of_space > req_i.req_addr) ?
              (cfg_i.end_of_space - req_i.req_addr) : '0;
    fill_in = (room < sbc_pkg::ADDR_W'(cap_eff)) ? room[sbc_pkg::WLEN_W-1:0] : cap_eff;
    over_in = req_i.req_len > sbc_pkg::LEN_W'(cap_eff);
  end

  assign push        = a_valid_q && plan_ready_i;
  assign req_ready_o = !a_valid_q || push;
  assign take        = req_valid_i && req_ready_o;

  always_comb begin
    fwd    = a_req_q.req_addr - ws_q;
    rev    = ws_q - a_req_q.req_addr;
    in_win = (a_req_q.req_addr >= ws_q) && (fwd < sbc_pkg::ADDR_W'(wlen_q));
    rest   = wlen_q - fwd[sbc_pkg::WLEN_W-1:0];
    hit    = (wlen_q != '0) && in_win && (a_req_q.req_len <= sbc_pkg::LEN_W'(rest));
    ovl    = (wlen_q != '0) &&
             (((ws_q >= a_req_q.req_addr) && (rev < sbc_pkg::ADDR_W'(a_req_q.req_len)))
              || in_win);

    plan.flush_en    = 1'b0;
    plan.refill_en   = 1'b0;
    plan.main_code   = a_req_q.req_type ? sbc_pkg::CMD_DIRECT_WR : sbc_pkg::CMD_DIRECT_RD;
    plan.flush_start = ws_q;
    plan.flush_len   = wlen_q;
    plan.fill_len    = a_fill_q;
    plan.addr        = a_req_q.req_addr;
    plan.len         = a_req_q.req_len;
    plan.offset      = '0;
    ws_d             = ws_q;
    wlen_d           = wlen_q;
    dirty_d          = dirty_q;

    if (!cfg_i.sieving_enabled) begin
      plan.main_code = a_req_q.req_type ? sbc_pkg::CMD_DIRECT_WR : sbc_pkg::CMD_DIRECT_RD;
    end else if (hit) begin
      plan.main_code = a_req_q.req_type ? sbc_pkg::CMD_COPY_IN : sbc_pkg::CMD_COPY_OUT;
      plan.offset    = fwd[sbc_pkg::OFF_W-1:0];
      if (a_req_q.req_type) begin
        dirty_d = 1'b1;
      end
    end else if (a_over_q) begin
      if (ovl) begin
        if (dirty_q) begin
          plan.flush_en = 1'b1;
          dirty_d       = 1'b0;
        end
        if (a_req_q.req_type) begin
          ws_d   = '0;
          wlen_d = '0;
        end
      end
    end else begin
      plan.flush_en  = dirty_q;
      plan.refill_en = 1'b1;
      plan.main_code = a_req_q.req_type ? sbc_pkg::CMD_COPY_IN : sbc_pkg::CMD_COPY_OUT;
      ws_d           = a_req_q.req_addr;
      wlen_d         = a_fill_q;
      dirty_d        = a_req_q.req_type;
    end
  end

  always_comb begin
    a_valid_d = a_valid_q;
    if (take) begin
      a_valid_d = 1'b1;
    end else if (push) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      ws_q      <= '0;
      wlen_q    <= '0;
      dirty_q   <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      if (push) begin
        ws_q    <= ws_d;
        wlen_q  <= wlen_d;
        dirty_q <= dirty_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_req_q  <= req_i;
      a_fill_q <= fill_in;
      a_over_q <= over_in;
    end
  end

  assign plan_valid_o = a_valid_q;
  assign plan_o       = plan;

endmodule

`default_nettype wire

@@ hw/rtl/sbc_queue.sv @@
// Two-entry plan queue between the front end and the command sequencer.
`default_nettype none

module sbc_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_valid_i,
  output logic           wr_ready_o,
  input  wire sbc_pkg::plan_t wr_data_i,
  output logic           rd_valid_o,
  input  wire logic      rd_ready_i,
  output sbc_pkg::plan_t rd_data_o
);

  sbc_pkg::plan_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           wr_fire, rd_fire;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr_fire    = wr_valid_i && wr_ready_o;
  assign rd_fire    = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (wr_fire && !rd_fire) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_fire && !wr_fire) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_fire) begin
        wptr_q <= !wptr_q;
      end
      if (rd_fire) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sbc_back.sv @@
// Back end: walks each plan and issues its flush, refill and final command in order.
`default_nettype none

module sbc_back (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      plan_valid_i,
  output logic           plan_ready_o,
  input  wire sbc_pkg::plan_t plan_i,
  output logic           cmd_valid_o,
  input  wire logic      cmd_ready_i,
  output sbc_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] STEP_FLUSH  = 2'd0;
  localparam logic [1:0] STEP_REFILL = 2'd1;
  localparam logic [1:0] STEP_MAIN   = 2'd2;

  sbc_pkg::plan_t plan_q;
  logic           busy_q, busy_d;
  logic [1:0]     step_q, step_d;
  logic           out_valid_q, out_valid_d;
  sbc_pkg::cmd_t  out_q;

  logic           emit;
  logic           cur_last;
  logic           pop;
  sbc_pkg::cmd_t  cur_cmd;
  logic [1:0]     step_after;
  logic [1:0]     step_first;

  assign emit = busy_q && (!out_valid_q || cmd_ready_i);
  assign pop  = plan_valid_i && (!busy_q || (emit && cur_last));
  assign plan_ready_o = !busy_q || (emit && cur_last);

  always_comb begin
    cur_cmd.cmd_code   = plan_q.main_code;
    cur_cmd.cmd_addr   = plan_q.addr;
    cur_cmd.cmd_len    = plan_q.len;
    cur_cmd.buf_offset = plan_q.offset;
    cur_cmd.last       = 1'b1;
    cur_last           = 1'b1;
    step_after         = STEP_MAIN;
    case (step_q)
      STEP_FLUSH: begin
        cur_cmd.cmd_code   = sbc_pkg::CMD_FLUSH;
        cur_cmd.cmd_addr   = plan_q.flush_start;
        cur_cmd.cmd_len    = sbc_pkg::LEN_W'(plan_q.flush_len);
        cur_cmd.buf_offset = '0;
        cur_cmd.last       = 1'b0;
        cur_last           = 1'b0;
        step_after         = plan_q.refill_en ? STEP_REFILL : STEP_MAIN;
      end
      STEP_REFILL: begin
        cur_cmd.cmd_code   = sbc_pkg::CMD_REFILL;
        cur_cmd.cmd_addr   = plan_q.addr;
        cur_cmd.cmd_len    = sbc_pkg::LEN_W'(plan_q.fill_len);
        cur_cmd.buf_offset = '0;
        cur_cmd.last       = 1'b0;
        cur_last           = 1'b0;
        step_after         = STEP_MAIN;
      end
      default: begin
        cur_last   = 1'b1;
        step_after = STEP_MAIN;
      end
    endcase
  end

  always_comb begin
    if (plan_i.flush_en) begin
      step_first = STEP_FLUSH;
    end else if (plan_i.refill_en) begin
      step_first = STEP_REFILL;
    end else begin
      step_first = STEP_MAIN;
    end

    busy_d = busy_q;
    step_d = step_q;
    if (pop) begin
      busy_d = 1'b1;
      step_d = step_first;
    end else if (emit) begin
      if (cur_last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_after;
      end
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (cmd_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_MAIN;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      plan_q <= plan_i;
    end
    if (emit) begin
      out_q <= cur_cmd;
    end
  end

  assign cmd_valid_o = out_valid_q;
  assign cmd_o       = out_q;

endmodule

`default_nettype wire

@@ hw/rtl/sbc_checker.sv @@
// Port-level checks on the command stream of the staging buffer controller, with its bind.
`default_nettype none

`include "assert_macros.svh"

module sbc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          cmd_valid_o,
  input wire logic          cmd_ready_i,
  input wire sbc_pkg::cmd_t cmd_o
);

  logic xfer;
  logic is_flush;
  logic is_refill;
  logic is_direct;
  logic is_copy;

  assign xfer      = cmd_valid_o && cmd_ready_i;
  assign is_flush  = cmd_o.cmd_code == sbc_pkg::CMD_FLUSH;
  assign is_refill = cmd_o.cmd_code == sbc_pkg::CMD_REFILL;
  assign is_direct = (cmd_o.cmd_code == sbc_pkg::CMD_DIRECT_RD) ||
                     (cmd_o.cmd_code == sbc_pkg::CMD_DIRECT_WR);
  assign is_copy   = (cmd_o.cmd_code == sbc_pkg::CMD_COPY_OUT) ||
                     (cmd_o.cmd_code == sbc_pkg::CMD_COPY_IN);

  `SBC_ASSERT_NEXT(a_cmd_hold, cmd_valid_o && !cmd_ready_i, cmd_valid_o && $stable(cmd_o))
  `SBC_ASSERT_NOW(a_flush_not_last, xfer && is_flush, !cmd_o.last && cmd_o.buf_offset == '0)
  `SBC_ASSERT_NOW(a_refill_not_last, xfer && is_refill, !cmd_o.last && cmd_o.buf_offset == '0)
  `SBC_ASSERT_NOW(a_direct_last, xfer && is_direct, cmd_o.last && cmd_o.buf_offset == '0)
  `SBC_ASSERT_NOW(a_offset_copy, xfer && cmd_o.buf_offset != '0, is_copy)

endmodule

bind sieve_buffer_controller sbc_checker u_sbc_checker (.*);

`default_nettype wire

@@ bench/sbc_cmd_checker.sv @@
// Checker for the staging buffer controller: predicts the command stream and compares transfers.
module sbc_cmd_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sbc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  sbc_pkg::req_t                  req_i,
  input  logic                           cmd_valid_i,
  input  logic                           cmd_ready_i,
  input  sbc_pkg::cmd_t                  cmd_i,
  output int                             mismatch_count_o,
  output int                             cmds_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic                       sieve_on;
  logic [sbc_pkg::WLEN_W-1:0] cap_reg;
  logic [sbc_pkg::ADDR_W-1:0] space_end;
  logic [sbc_pkg::ADDR_W-1:0] win_start;
  logic [sbc_pkg::WLEN_W-1:0] win_len;
  logic                       win_dirty;
  sbc_pkg::cmd_t              due_cmds[$];

  task automatic report_mismatch(input string msg);
    mismatch_count_o++;
    if (mismatch_count_o <= 50) begin
      $display("%0t ns: command mismatch: %s", $time, msg);
    end
  endtask

  task automatic queue_command(input sbc_pkg::cmd_code_e code, input logic [63:0] addr,
                               input logic [63:0] len, input logic [63:0] offs,
                               input logic last);
    sbc_pkg::cmd_t c;
    c.cmd_code   = code;
    c.cmd_addr   = addr[sbc_pkg::ADDR_W-1:0];
    c.cmd_len    = len[sbc_pkg::LEN_W-1:0];
    c.buf_offset = offs[sbc_pkg::OFF_W-1:0];
    c.last       = last;
    due_cmds.push_back(c);
  endtask

  task automatic predict_commands(input sbc_pkg::req_t r);
    logic [63:0]        addr;
    logic [63:0]        len;
    logic [63:0]        cap;
    logic [63:0]        ws;
    logic [63:0]        wl;
    logic [63:0]        room;
    logic               overlap;
    sbc_pkg::cmd_code_e copy_code;
    sbc_pkg::cmd_code_e direct_code;
    addr = 64'(r.req_addr);
    len  = 64'(r.req_len);
    ws   = 64'(win_start);
    wl   = 64'(win_len);
    copy_code   = r.req_type ? sbc_pkg::CMD_COPY_IN : sbc_pkg::CMD_COPY_OUT;
    direct_code = r.req_type ? sbc_pkg::CMD_DIRECT_WR : sbc_pkg::CMD_DIRECT_RD;
    if (cap_reg == '0) begin
      cap = 64'd1;
    end else if (cap_reg > sbc_pkg::CAP_MAX) begin
      cap = 64'(sbc_pkg::CAP_MAX);
    end else begin
      cap = 64'(cap_reg);
    end
    if (!sieve_on) begin
      queue_command(direct_code, addr, len, 64'd0, 1'b1);
    end else if (wl != 0 && addr >= ws && addr - ws < wl && len <= wl - (addr - ws)) begin
      if (r.req_type) win_dirty = 1'b1;
      queue_command(copy_code, addr, len, addr - ws, 1'b1);
    end else if (len > cap) begin
      overlap = wl != 0 && ((ws >= addr && ws - addr < len) || (addr >= ws && addr - ws < wl));
      if (overlap && win_dirty) begin
        queue_command(sbc_pkg::CMD_FLUSH, ws, wl, 64'd0, 1'b0);
        win_dirty = 1'b0;
      end
      if (overlap && r.req_type) begin
        win_start = '0;
        win_len   = '0;
      end
      queue_command(direct_code, addr, len, 64'd0, 1'b1);
    end else begin
      if (win_dirty) begin
        queue_command(sbc_pkg::CMD_FLUSH, ws, wl, 64'd0, 1'b0);
      end
      room      = (64'(space_end) > addr) ? 64'(space_end) - addr : 64'd0;
      win_start = r.req_addr;
      win_len   = sbc_pkg::WLEN_W'((room < cap) ? room : cap);
      win_dirty = r.req_type;
      queue_command(sbc_pkg::CMD_REFILL, addr, 64'(win_len), 64'd0, 1'b0);
      queue_command(copy_code, addr, len, 64'd0, 1'b1);
    end
  endtask

  task automatic check_command(input sbc_pkg::cmd_t got);
    sbc_pkg::cmd_t want;
    if (due_cmds.size() == 0) begin
      report_mismatch($sformatf("unexpected command code %0d addr %0h", got.cmd_code,
                                got.cmd_addr));
    end else begin
      want = due_cmds.pop_front();
      if (got.cmd_code !== want.cmd_code)
        report_mismatch($sformatf("cmd_code %0d, expected %0d", got.cmd_code, want.cmd_code));
      if (got.cmd_addr !== want.cmd_addr)
        report_mismatch($sformatf("cmd_addr %0h, expected %0h", got.cmd_addr, want.cmd_addr));
      if (got.cmd_len !== want.cmd_len)
        report_mismatch($sformatf("cmd_len %0h, expected %0h", got.cmd_len, want.cmd_len));
      if (got.buf_offset !== want.buf_offset)
        report_mismatch($sformatf("buf_offset %0h, expected %0h", got.buf_offset,
                                  want.buf_offset));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sieve_on  = 1'b1;
      cap_reg   = sbc_pkg::CAP_RESET;
      space_end = '0;
      win_start = '0;
      win_len   = '0;
      win_dirty = 1'b0;
      due_cmds.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sbc_pkg::CFG_SIEVING:  sieve_on  = cfg_wdata_i[0];
          sbc_pkg::CFG_CAPACITY: cap_reg   = cfg_wdata_i[sbc_pkg::WLEN_W-1:0];
          sbc_pkg::CFG_END:      space_end = cfg_wdata_i[sbc_pkg::ADDR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid_i === 1'b1 && cmd_ready_i) check_command(cmd_i);
      if (req_valid_i && req_ready_i === 1'b1) predict_commands(req_i);
    end
    cmds_due_o = due_cmds.size();
  end

endmodule

@@ bench/tb.sv @@
// Testbench top for the staging buffer controller: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [sbc_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [sbc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           req_valid = 1'b0;
  logic                           req_ready;
  sbc_pkg::req_t                  req       = '0;
  logic                           cmd_valid;
  logic                           cmd_ready = 1'b0;
  sbc_pkg::cmd_t                  cmd;
  int                             mismatch_count;
  int                             cmds_due;
  int unsigned                    cycle_count = 0;

  logic                           steady        = 1'b0;
  int unsigned                    span          = 65536;
  logic [sbc_pkg::ADDR_W-1:0]     space_end_now = '0;
  logic [sbc_pkg::ADDR_W-1:0]     win_base      = '0;

  sieve_buffer_controller dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  sbc_cmd_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .req_valid_i      (req_valid),
    .req_ready_i      (req_ready),
    .req_i            (req),
    .cmd_valid_i      (cmd_valid),
    .cmd_ready_i      (cmd_ready),
    .cmd_i            (cmd),
    .mismatch_count_o (mismatch_count),
    .cmds_due_o       (cmds_due)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    cmd_ready <= steady || ($urandom_range(0, 99) >= 8);
  end

  function automatic logic [sbc_pkg::ADDR_W-1:0] rand_addr();
    return sbc_pkg::ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic sbc_pkg::req_t make_req(input logic wr,
                                             input logic [sbc_pkg::ADDR_W-1:0] addr,
                                             input logic [sbc_pkg::LEN_W-1:0] len);
    sbc_pkg::req_t r;
    r.req_type = wr;
    r.req_addr = addr;
    r.req_len  = len;
    return r;
  endfunction

  task automatic push_request(input sbc_pkg::req_t item);
    while (!steady && $urandom_range(0, 99) < 8) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    do @(negedge clk); while (cmds_due != 0);
  endtask

  task automatic write_config(input logic sieve, input logic [sbc_pkg::WLEN_W-1:0] cap,
                              input logic [sbc_pkg::ADDR_W-1:0] space_end);
    cfg_we    <= 1'b1;
    cfg_idx   <= sbc_pkg::CFG_SIEVING;
    cfg_wdata <= sbc_pkg::CFG_DATA_W'(sieve);
    @(negedge clk);
    cfg_idx   <= sbc_pkg::CFG_CAPACITY;
    cfg_wdata <= sbc_pkg::CFG_DATA_W'(cap);
    @(negedge clk);
    cfg_idx   <= sbc_pkg::CFG_END;
    cfg_wdata <= space_end;
    @(negedge clk);
    cfg_we    <= 1'b0;
    span          = (cap == '0) ? 1 :
                    ((cap > sbc_pkg::CAP_MAX) ? sbc_pkg::MAX_CAPACITY : int'(cap));
    space_end_now = space_end;
  endtask

  task automatic random_request(output sbc_pkg::req_t r);
    logic [63:0] addr;
    logic [31:0] len;
    int unsigned pick;
    int unsigned offs;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      if (space_end_now == '0 || $urandom_range(0, 3) == 0) begin
        win_base = rand_addr();
      end else if ($urandom_range(0, 2) == 0) begin
        win_base = (space_end_now > span) ? space_end_now - $urandom_range(0, span) : '0;
      end else begin
        win_base = rand_addr() % space_end_now;
      end
      addr = 64'(win_base);
      len  = $urandom_range(0, span);
    end else if (pick < 65) begin
      offs = $urandom_range(0, span - 1);
      addr = 64'(win_base) + offs;
      len  = $urandom_range(0, span - offs);
    end else if (pick < 77) begin
      offs = $urandom_range(0, 2 * span);
      addr = 64'(win_base) + offs - span;
      len  = $urandom_range(0, 1) ? $urandom : span + $urandom_range(1, 2 * span);
    end else if (pick < 85) begin
      addr = 64'(win_base) + $urandom_range(0, span);
      len  = '0;
    end else begin
      addr = 64'(rand_addr());
      len  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2 * span);
    end
    r = make_req($urandom_range(0, 1), addr[sbc_pkg::ADDR_W-1:0], len);
  endtask

  initial begin
    sbc_pkg::req_t              item;
    int unsigned                sent;
    int unsigned                phase;
    int unsigned                n;
    logic                       sieve;
    logic [sbc_pkg::WLEN_W-1:0] cap;
    logic [sbc_pkg::ADDR_W-1:0] space_end;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: the space end is zero, so every refill is empty.
    push_request(make_req(1'b0, '0, '0));
    push_request(make_req(1'b1, '1, 32'd1));
    push_request(make_req(1'b0, 48'd5, 32'd10));
    push_request(make_req(1'b0, '0, '1));

    settle();
    write_config(1'b1, '0, '1);
    push_request(make_req(1'b1, 48'd100, 32'd1));
    push_request(make_req(1'b1, 48'd100, 32'd1));
    push_request(make_req(1'b0, 48'd100, 32'd0));
    push_request(make_req(1'b0, 48'd101, 32'd1));
    push_request(make_req(1'b0, 48'd101, 32'd2));

    settle();
    write_config(1'b1, '1, '1);
    push_request(make_req(1'b1, 48'h1000, 32'h100));
    push_request(make_req(1'b1, 48'h1000 + 48'hFFFFF, 32'd1));
    push_request(make_req(1'b0, 48'h1000, 32'h100000));
    push_request(make_req(1'b1, 48'h800, 32'h100001));
    push_request(make_req(1'b0, 48'h1000, 32'd4));
    push_request(make_req(1'b0, 48'h0, 32'h200000));
    push_request(make_req(1'b1, 48'h1004, 32'd4));
    push_request(make_req(1'b0, 48'h200000, 32'h200000));

    settle();
    write_config(1'b1, sbc_pkg::CAP_MAX, 48'h200000);
    push_request(make_req(1'b0, 48'h1FFF00, 32'h10));
    push_request(make_req(1'b0, 48'h300000, 32'd8));
    push_request(make_req(1'b1, 48'h200000, 32'd1));

    settle();
    write_config(1'b0, sbc_pkg::CAP_MAX, 48'h200000);
    push_request(make_req(1'b1, '1, '1));
    push_request(make_req(1'b0, '0, '0));

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      sieve = (phase == 0) || ($urandom_range(0, 5) != 0);
      case ($urandom_range(0, 7))
        0: cap = '0;
        1: cap = sbc_pkg::WLEN_W'(1);
        2: cap = sbc_pkg::WLEN_W'($urandom_range(2, 64));
        3: cap = sbc_pkg::WLEN_W'(256);
        4: cap = sbc_pkg::CAP_RESET;
        5: cap = sbc_pkg::CAP_MAX;
        6: cap = '1;
        default: cap = sbc_pkg::WLEN_W'($urandom_range(1, 2 ** sbc_pkg::WLEN_W - 1));
      endcase
      case ($urandom_range(0, 5))
        0: space_end = '0;
        1, 2: space_end = '1;
        3, 4: space_end = rand_addr();
        default: space_end = sbc_pkg::ADDR_W'($urandom_range(1, 1 << 21));
      endcase
      write_config(sieve, cap, space_end);
      win_base = (space_end == '0) ? rand_addr() : rand_addr() % space_end;
      steady = (phase == 2);
      n = $urandom_range(30, 60);
      for (int unsigned i = 0; i < n; i++) begin
        if (phase == 1 && i == n / 2) settle();
        random_request(item);
        push_request(item);
        sent++;
      end
      steady = 1'b0;
      phase++;
    end

    settle();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
